>>> design/ccse_pkg.sv
package ccse_pkg;

  localparam int VAL_W     = 24;
  localparam int COORD_W   = 12;
  localparam int STEP_W    = 6;
  // Crossing offset along a side is always below the step, so it fits the step width.
  localparam int QUO_W     = STEP_W;
  localparam int NUM_W     = VAL_W + STEP_W;
  localparam int CNT_W     = $clog2(QUO_W);
  localparam int NUM_SIDES = 4;

  localparam logic [STEP_W-1:0] CELL_STEP_RESET = 6'd5;

  typedef enum logic [1:0] {
    SIDE_TOP,
    SIDE_BOTTOM,
    SIDE_LEFT,
    SIDE_RIGHT
  } ccse_side_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIDE,
    ST_WAIT,
    ST_EMIT0,
    ST_EMIT1
  } ccse_state_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] corner_top_left;
    logic signed [VAL_W-1:0] corner_top_right;
    logic signed [VAL_W-1:0] corner_bottom_left;
    logic signed [VAL_W-1:0] corner_bottom_right;
    logic signed [VAL_W-1:0] level;
    logic [COORD_W-1:0]      cell_column;
    logic [COORD_W-1:0]      cell_row;
    logic                    first_row;
    logic                    may_hand_down;
  } ccse_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic               final_segment;
  } ccse_out_t;

  typedef struct packed {
    logic                    start;
    logic signed [VAL_W-1:0] lv;
    logic signed [VAL_W-1:0] za;
    logic signed [VAL_W-1:0] zb;
    logic [COORD_W-1:0]      pos;
  } ccse_div_req_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] coord;
  } ccse_div_rsp_t;

  function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                 input logic [STEP_W-1:0]  b);
    logic [COORD_W:0] s;
    s = {1'b0, a} + {{(COORD_W + 1 - STEP_W){1'b0}}, b};
    return s[COORD_W] ? {COORD_W{1'b1}} : s[COORD_W-1:0];
  endfunction

  function automatic logic crosses(input logic signed [VAL_W-1:0] lv,
                                   input logic signed [VAL_W-1:0] za,
                                   input logic signed [VAL_W-1:0] zb);
    return ((lv < zb) && (lv > za)) || ((lv < za) && (lv > zb));
  endfunction

endpackage

>>> design/ccse_if.sv
interface ccse_in_if;
  import ccse_pkg::*;
  logic     valid;
  logic     ready;
  ccse_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ccse_out_if;
  import ccse_pkg::*;
  logic      valid;
  logic      ready;
  ccse_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/ccse_div.sv
module ccse_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ccse_pkg::ccse_div_req_t       req_i,
  input  logic [ccse_pkg::STEP_W-1:0]   step_i,
  output ccse_pkg::ccse_div_rsp_t       rsp_o
);
  import ccse_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] rem_q;
  logic [VAL_W-1:0] den_q;
  logic [QUO_W-1:0] quo_q;
  logic [COORD_W-1:0] pos_q;

  logic signed [VAL_W:0] diff_n;
  logic signed [VAL_W:0] diff_d;
  logic [VAL_W-1:0]      mag_n;
  logic [VAL_W-1:0]      mag_d;
  logic [NUM_W-1:0]      prod;
  logic [NUM_W-1:0]      shifted;
  logic                  fits;

  always_comb begin
    diff_n = {req_i.lv[VAL_W-1], req_i.lv} - {req_i.za[VAL_W-1], req_i.za};
    diff_d = {req_i.zb[VAL_W-1], req_i.zb} - {req_i.za[VAL_W-1], req_i.za};
    mag_n  = diff_n[VAL_W] ? VAL_W'(-diff_n) : diff_n[VAL_W-1:0];
    mag_d  = diff_d[VAL_W] ? VAL_W'(-diff_d) : diff_d[VAL_W-1:0];
    // Level lies strictly between the corners, so both differences share a sign.
    prod    = {{STEP_W{1'b0}}, mag_n} * {{VAL_W{1'b0}}, step_i};
    shifted = {{STEP_W{1'b0}}, den_q} << cnt_q;
    fits    = (rem_q >= shifted);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(QUO_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // One restoring quotient bit per cycle, most significant first.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= prod;
      den_q <= mag_d;
      quo_q <= '0;
      pos_q <= req_i.pos;
    end else if (busy_q && fits) begin
      rem_q        <= rem_q - shifted;
      quo_q[cnt_q] <= 1'b1;
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.coord = sat_add(pos_q, quo_q);

endmodule

>>> design/contour_cell_segment_extract.sv
// Sequence: an accepted cell visits the sides top, bottom, left, right in turn; each side
// whose crossing must be computed starts the shared 6-step divider and waits for it, each
// side without one is passed over, and the segments are then loaded one by one.
// Throughput: one cell at a time; the next cell is taken the cycle after the last segment
// is loaded (or after the emit state for a cell without segments); output stalls delay it.
// Reset: cell_step returns to 5 and the handed-down bottom point is cleared.
module contour_cell_segment_extract (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ccse_in_if.sink                       cell_i,
  ccse_out_if.source                    seg_o,
  input  logic                          cfg_we_i,
  input  logic [ccse_pkg::STEP_W-1:0]   cfg_wdata_i
);
  import ccse_pkg::*;

  ccse_state_e state_q, state_d;
  ccse_side_e  side_q, side_d;

  logic [STEP_W-1:0]    step_q;
  ccse_in_t             item_q;
  logic [NUM_SIDES-1:0] need_q;
  logic [NUM_SIDES-1:0] pres_q;
  logic [COORD_W-1:0]   pnt_x_q [NUM_SIDES];
  logic [COORD_W-1:0]   pnt_y_q [NUM_SIDES];
  logic [COORD_W-1:0]   handed_x_q;
  logic [COORD_W-1:0]   handed_y_q;
  logic                 handed_valid_q;
  ccse_out_t            seg_q;
  logic                 seg_valid_q;

  logic          accept;
  logic          can_load;
  logic          load0;
  logic          load1;
  logic          cr_top, cr_bot, cr_left, cr_right;
  logic [1:0]    nseg;
  ccse_out_t     seg0, seg1;
  ccse_div_req_t div_req;
  ccse_div_rsp_t div_rsp;

  assign accept       = cell_i.valid && cell_i.ready;
  assign cell_i.ready = (state_q == ST_IDLE);
  assign can_load     = !seg_valid_q || seg_o.ready;
  assign load0        = (state_q == ST_EMIT0) && (nseg != 2'd0) && can_load;
  assign load1        = (state_q == ST_EMIT1) && can_load;

  always_comb begin
    cr_top   = crosses(cell_i.data.level, cell_i.data.corner_top_left,
                       cell_i.data.corner_top_right);
    cr_bot   = crosses(cell_i.data.level, cell_i.data.corner_bottom_left,
                       cell_i.data.corner_bottom_right);
    cr_left  = crosses(cell_i.data.level, cell_i.data.corner_top_left,
                       cell_i.data.corner_bottom_left);
    cr_right = crosses(cell_i.data.level, cell_i.data.corner_top_right,
                       cell_i.data.corner_bottom_right);
  end

  // Operand selection for the shared divider.
  always_comb begin
    div_req.start = (state_q == ST_SIDE) && need_q[side_q];
    div_req.lv    = item_q.level;
    case (side_q)
      SIDE_TOP: begin
        div_req.za  = item_q.corner_top_left;
        div_req.zb  = item_q.corner_top_right;
        div_req.pos = item_q.cell_column;
      end
      SIDE_BOTTOM: begin
        div_req.za  = item_q.corner_bottom_left;
        div_req.zb  = item_q.corner_bottom_right;
        div_req.pos = item_q.cell_column;
      end
      SIDE_LEFT: begin
        div_req.za  = item_q.corner_top_left;
        div_req.zb  = item_q.corner_bottom_left;
        div_req.pos = item_q.cell_row;
      end
      default: begin
        div_req.za  = item_q.corner_top_right;
        div_req.zb  = item_q.corner_bottom_right;
        div_req.pos = item_q.cell_row;
      end
    endcase
  end

  ccse_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .step_i (step_q),
    .rsp_o  (div_rsp)
  );

  function automatic ccse_out_t mk_seg(input ccse_side_e a, input ccse_side_e b,
                                       input logic fin);
    ccse_out_t s;
    s.start_x       = pnt_x_q[a];
    s.start_y       = pnt_y_q[a];
    s.end_x         = pnt_x_q[b];
    s.end_y         = pnt_y_q[b];
    s.final_segment = fin;
    return s;
  endfunction

  // pres_q bits: right, left, bottom, top.
  always_comb begin
    nseg = 2'd0;
    seg0 = mk_seg(SIDE_TOP, SIDE_BOTTOM, 1'b1);
    seg1 = mk_seg(SIDE_RIGHT, SIDE_LEFT, 1'b1);
    case (pres_q)
      4'b1111: begin
        nseg = 2'd2;
        seg0 = mk_seg(SIDE_TOP, SIDE_BOTTOM, 1'b0);
        seg1 = mk_seg(SIDE_RIGHT, SIDE_LEFT, 1'b1);
      end
      4'b1110: begin
        nseg = 2'd2;
        seg0 = mk_seg(SIDE_LEFT, SIDE_BOTTOM, 1'b0);
        seg1 = mk_seg(SIDE_BOTTOM, SIDE_RIGHT, 1'b1);
      end
      4'b1011: begin
        nseg = 2'd2;
        seg0 = mk_seg(SIDE_TOP, SIDE_RIGHT, 1'b0);
        seg1 = mk_seg(SIDE_RIGHT, SIDE_BOTTOM, 1'b1);
      end
      4'b1101: begin
        nseg = 2'd2;
        seg0 = mk_seg(SIDE_LEFT, SIDE_TOP, 1'b0);
        seg1 = mk_seg(SIDE_TOP, SIDE_RIGHT, 1'b1);
      end
      4'b0111: begin
        nseg = 2'd2;
        seg0 = mk_seg(SIDE_TOP, SIDE_LEFT, 1'b0);
        seg1 = mk_seg(SIDE_LEFT, SIDE_BOTTOM, 1'b1);
      end
      4'b0011: begin
        nseg = 2'd1;
        seg0 = mk_seg(SIDE_TOP, SIDE_BOTTOM, 1'b1);
      end
      4'b0101: begin
        nseg = 2'd1;
        seg0 = mk_seg(SIDE_TOP, SIDE_LEFT, 1'b1);
      end
      4'b1001: begin
        nseg = 2'd1;
        seg0 = mk_seg(SIDE_TOP, SIDE_RIGHT, 1'b1);
      end
      4'b0110: begin
        nseg = 2'd1;
        seg0 = mk_seg(SIDE_BOTTOM, SIDE_LEFT, 1'b1);
      end
      4'b1010: begin
        nseg = 2'd1;
        seg0 = mk_seg(SIDE_BOTTOM, SIDE_RIGHT, 1'b1);
      end
      4'b1100: begin
        nseg = 2'd1;
        seg0 = mk_seg(SIDE_LEFT, SIDE_RIGHT, 1'b1);
      end
      default: begin
        nseg = 2'd0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    side_d  = side_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SIDE;
          side_d  = SIDE_TOP;
        end
      end
      ST_SIDE: begin
        if (need_q[side_q]) begin
          state_d = ST_WAIT;
        end else if (side_q == SIDE_RIGHT) begin
          state_d = ST_EMIT0;
        end else begin
          side_d = ccse_side_e'(side_q + 2'd1);
        end
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          if (side_q == SIDE_RIGHT) begin
            state_d = ST_EMIT0;
          end else begin
            state_d = ST_SIDE;
            side_d  = ccse_side_e'(side_q + 2'd1);
          end
        end
      end
      ST_EMIT0: begin
        if (nseg == 2'd0) begin
          state_d = ST_IDLE;
        end else if (can_load) begin
          state_d = (nseg == 2'd2) ? ST_EMIT1 : ST_IDLE;
        end
      end
      ST_EMIT1: begin
        if (can_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q         <= SIDE_TOP;
      step_q         <= CELL_STEP_RESET;
      need_q         <= '0;
      pres_q         <= '0;
      handed_x_q     <= '0;
      handed_y_q     <= '0;
      handed_valid_q <= 1'b0;
      seg_valid_q    <= 1'b0;
    end else begin
      side_q <= side_d;
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      if (accept) begin
        need_q <= {cr_right, cr_left, cr_bot,
                   !handed_valid_q && cell_i.data.first_row && cr_top};
        pres_q <= {cr_right, cr_left, cr_bot,
                   handed_valid_q || (cell_i.data.first_row && cr_top)};
        // The handed point is consumed by every cell.
        handed_valid_q <= 1'b0;
      end else if ((state_q == ST_WAIT) && div_rsp.done && (side_q == SIDE_BOTTOM)
                   && item_q.may_hand_down) begin
        handed_x_q     <= div_rsp.coord;
        handed_y_q     <= pnt_y_q[SIDE_BOTTOM];
        handed_valid_q <= 1'b1;
      end
      if (load0 || load1) begin
        seg_valid_q <= 1'b1;
      end else if (seg_o.ready) begin
        seg_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q               <= cell_i.data;
      pnt_x_q[SIDE_TOP]    <= handed_x_q;
      pnt_y_q[SIDE_TOP]    <= handed_valid_q ? handed_y_q : cell_i.data.cell_row;
      pnt_y_q[SIDE_BOTTOM] <= sat_add(cell_i.data.cell_row, step_q);
      pnt_x_q[SIDE_LEFT]   <= cell_i.data.cell_column;
      pnt_x_q[SIDE_RIGHT]  <= sat_add(cell_i.data.cell_column, step_q);
    end else if ((state_q == ST_WAIT) && div_rsp.done) begin
      if ((side_q == SIDE_TOP) || (side_q == SIDE_BOTTOM)) begin
        pnt_x_q[side_q] <= div_rsp.coord;
      end else begin
        pnt_y_q[side_q] <= div_rsp.coord;
      end
    end
    if (load0) begin
      seg_q <= seg0;
    end else if (load1) begin
      seg_q <= seg1;
    end
  end

  assign seg_o.valid = seg_valid_q;
  assign seg_o.data  = seg_q;

  a_no_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_rsp.done)
    else $error("divider finished while no cell in work");

  a_start_only_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> need_q[side_q])
    else $error("divider started for a side without a crossing");

  a_hand_from_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(handed_valid_q) |-> $past((state_q == ST_WAIT) && (side_q == SIDE_BOTTOM)))
    else $error("handed point set outside the bottom crossing");

  a_second_seg_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT1) |-> ($countones(pres_q) >= 3))
    else $error("second segment with fewer than three points");

endmodule
